// File: rtl/rmt_pkg.sv
package rmt_pkg;

    localparam int PAGE_BITS     = 12;
    localparam int ADDR_W        = 64;
    localparam int PAGE_W        = ADDR_W - PAGE_BITS;
    localparam int SIZE_W        = 16;
    localparam int MAX_SPANS_DEF = 64;
    localparam logic [ADDR_W-1:0] PAGE_MASK = 64'hFFF;

    typedef enum logic [1:0] {
        CMD_MAP    = 2'd0,
        CMD_UNMAP  = 2'd1,
        CMD_REJECT = 2'd2,
        CMD_FULL   = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        RS_IDX,
        RS_PTR,
        RS_PTRM1
    } t_rd_src;

    typedef enum logic [2:0] {
        W_HEAD,
        W_LMAX,
        W_LRE,
        W_RSP,
        W_SHUP,
        W_SHDN,
        W_INS
    } t_wr_sel;

    typedef enum logic [2:0] {
        P_HOLD,
        P_TOTAL,
        P_I2,
        P_INC,
        P_DEC
    } t_ptr_op;

    typedef enum logic [2:0] {
        ES_IN,
        ES_LEFT,
        ES_RIGHT,
        ES_LMAX,
        ES_HEAD,
        ES_SPRE,
        ES_LRE
    } t_emit_sel;

    typedef struct packed {
        logic      load_in;
        logic      rd_en;
        t_rd_src   rd_src;
        logic      cap_left;
        logic      cap_right;
        logic      idx_inc;
        logic      wr_en;
        t_wr_sel   wr_sel;
        t_ptr_op   ptr_op;
        logic      pos_set;
        logic      pos_i1;
        logic      tot_inc;
        logic      tot_dec;
        logic      emit;
        t_cmd_code emit_cmd;
        t_emit_sel emit_sel;
        logic      emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic reject;
        logic empty;
        logic full;
        logic head_le;
        logic head_ep_ge;
        logic rd_lt_sp;
        logic at_last;
        logic idx_zero;
        logic left_hit;
        logic right_hit;
        logic ptr_gt_pos;
        logic ptr_lt_total;
        logic out_free;
    } t_dp_stat;

endpackage

// File: rtl/rmt_ram.sv
module rmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/rmt_ctrl.sv
module rmt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rmt_pkg::t_dp_stat i_stat,
    output rmt_pkg::t_dp_cmd  o_cmd
);
    import rmt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_RD, S_CHK, S_TAIL, S_MID,
        S_LU, S_LW, S_RU, S_RW, S_DU1, S_DU2, S_DW, S_DL, S_DLW,
        S_HU, S_HW, S_INS, S_SHC, S_SHW, S_INW, S_FIN
    } t_state;

    t_state    r_state, n_state;
    t_cmd_code r_fcmd, n_fcmd;
    t_emit_sel r_fsel, n_fsel;
    t_dp_cmd   c;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        c         = '0;
        c.rd_src  = RS_IDX;
        c.wr_sel  = W_INS;
        c.ptr_op  = P_HOLD;
        c.emit_cmd = CMD_MAP;
        c.emit_sel = ES_IN;
        n_state   = r_state;
        n_fcmd    = r_fcmd;
        n_fsel    = r_fsel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    c.load_in = 1'b1;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.reject) begin
                    n_fcmd  = CMD_REJECT;
                    n_fsel  = ES_IN;
                    n_state = S_FIN;
                end else if (i_stat.empty) begin
                    c.pos_set = 1'b1;
                    n_state   = S_INS;
                end else begin
                    c.rd_en = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_RD: begin
                c.rd_en = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_stat.idx_zero) begin
                    c.cap_left = 1'b1;
                    if (i_stat.head_le) begin
                        if (i_stat.head_ep_ge) begin
                            n_state = S_HU;
                        end else begin
                            c.pos_set = 1'b1;
                            n_state   = S_INS;
                        end
                    end else if (i_stat.at_last) begin
                        n_state = S_TAIL;
                    end else begin
                        c.idx_inc = 1'b1;
                        n_state   = S_RD;
                    end
                end else if (i_stat.rd_lt_sp) begin
                    c.cap_left = 1'b1;
                    if (i_stat.at_last) begin
                        n_state = S_TAIL;
                    end else begin
                        c.idx_inc = 1'b1;
                        n_state   = S_RD;
                    end
                end else begin
                    c.cap_right = 1'b1;
                    n_state     = S_MID;
                end
            end
            S_TAIL: begin
                if (i_stat.left_hit) begin
                    n_state = S_LU;
                end else begin
                    c.pos_set = 1'b1;
                    c.pos_i1  = 1'b1;
                    n_state   = S_INS;
                end
            end
            S_MID: begin
                if (i_stat.left_hit && i_stat.right_hit) begin
                    n_state = S_DU1;
                end else if (i_stat.left_hit) begin
                    n_state = S_LU;
                end else if (i_stat.right_hit) begin
                    n_state = S_RU;
                end else begin
                    c.pos_set = 1'b1;
                    c.pos_i1  = 1'b1;
                    n_state   = S_INS;
                end
            end
            S_LU, S_HU, S_DU1: begin
                c.emit     = i_stat.out_free;
                c.emit_cmd = CMD_UNMAP;
                c.emit_sel = ES_LEFT;
                if (i_stat.out_free) begin
                    n_state = (r_state == S_LU) ? S_LW : (r_state == S_HU) ? S_HW : S_DU2;
                end
            end
            S_RU, S_DU2: begin
                c.emit     = i_stat.out_free;
                c.emit_cmd = CMD_UNMAP;
                c.emit_sel = ES_RIGHT;
                if (i_stat.out_free) begin
                    n_state = (r_state == S_RU) ? S_RW : S_DW;
                end
            end
            S_LW: begin
                c.wr_en  = 1'b1;
                c.wr_sel = W_LMAX;
                n_fcmd   = CMD_MAP;
                n_fsel   = ES_LMAX;
                n_state  = S_FIN;
            end
            S_RW: begin
                c.wr_en  = 1'b1;
                c.wr_sel = W_RSP;
                n_fcmd   = CMD_MAP;
                n_fsel   = ES_SPRE;
                n_state  = S_FIN;
            end
            S_HW: begin
                c.wr_en  = 1'b1;
                c.wr_sel = W_HEAD;
                n_fcmd   = CMD_MAP;
                n_fsel   = ES_HEAD;
                n_state  = S_FIN;
            end
            S_DW: begin
                c.wr_en  = 1'b1;
                c.wr_sel = W_LRE;
                c.ptr_op = P_I2;
                n_state  = S_DL;
            end
            S_DL: begin
                // close the gap left by the right range
                if (i_stat.ptr_lt_total) begin
                    c.rd_en  = 1'b1;
                    c.rd_src = RS_PTR;
                    n_state  = S_DLW;
                end else begin
                    c.tot_dec = 1'b1;
                    n_fcmd    = CMD_MAP;
                    n_fsel    = ES_LRE;
                    n_state   = S_FIN;
                end
            end
            S_DLW: begin
                c.wr_en  = 1'b1;
                c.wr_sel = W_SHDN;
                c.ptr_op = P_INC;
                n_state  = S_DL;
            end
            S_INS: begin
                if (i_stat.full) begin
                    n_fcmd  = CMD_FULL;
                    n_fsel  = ES_IN;
                    n_state = S_FIN;
                end else begin
                    c.ptr_op = P_TOTAL;
                    n_state  = S_SHC;
                end
            end
            S_SHC: begin
                // open a slot at the insert position, top entry first
                if (i_stat.ptr_gt_pos) begin
                    c.rd_en  = 1'b1;
                    c.rd_src = RS_PTRM1;
                    n_state  = S_SHW;
                end else begin
                    n_state = S_INW;
                end
            end
            S_SHW: begin
                c.wr_en  = 1'b1;
                c.wr_sel = W_SHUP;
                c.ptr_op = P_DEC;
                n_state  = S_SHC;
            end
            S_INW: begin
                c.wr_en   = 1'b1;
                c.wr_sel  = W_INS;
                c.tot_inc = 1'b1;
                n_fcmd    = CMD_MAP;
                n_fsel    = ES_IN;
                n_state   = S_FIN;
            end
            S_FIN: begin
                c.emit      = i_stat.out_free;
                c.emit_cmd  = r_fcmd;
                c.emit_sel  = r_fsel;
                c.emit_last = 1'b1;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fcmd  <= CMD_MAP;
            r_fsel  <= ES_IN;
        end else begin
            r_state <= n_state;
            r_fcmd  <= n_fcmd;
            r_fsel  <= n_fsel;
        end
    end
endmodule

// File: rtl/rmt_dp.sv
module rmt_dp #(
    parameter int MAX_SPANS = rmt_pkg::MAX_SPANS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rmt_pkg::t_dp_cmd            i_cmd,
    output rmt_pkg::t_dp_stat           o_stat,
    input  logic [rmt_pkg::ADDR_W-1:0]  i_fault_address,
    input  logic [rmt_pkg::SIZE_W-1:0]  i_access_size,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_command,
    output logic [rmt_pkg::ADDR_W-1:0]  o_range_start,
    output logic [rmt_pkg::ADDR_W-1:0]  o_range_end,
    output logic                        o_last_of_run
);
    import rmt_pkg::*;

    localparam int IW = $clog2(MAX_SPANS);
    localparam int CW = $clog2(MAX_SPANS + 1);

    logic [PAGE_W-1:0] r_sp, r_ep, r_lf, r_le, r_rf, r_re;
    logic [IW-1:0]     r_idx, r_i;
    logic [CW-1:0]     r_ptr, r_pos, r_total;
    logic              r_ov;
    logic [1:0]        r_ocmd;
    logic [PAGE_W-1:0] r_ostart, r_oend;
    logic              r_olast;

    logic [ADDR_W-1:0]   sum;
    logic [PAGE_W-1:0]   max_le_ep, rd_first, rd_end, w_first, w_end, e_first, e_end;
    logic [2*PAGE_W-1:0] rdata, wdata;
    logic [IW-1:0]       raddr, waddr;
    logic [CW-1:0]       i_plus1, i_plus2;

    assign sum       = i_fault_address + {{(ADDR_W-SIZE_W){1'b0}}, i_access_size} + PAGE_MASK;
    assign max_le_ep = (r_le > r_ep) ? r_le : r_ep;
    assign rd_first  = rdata[2*PAGE_W-1:PAGE_W];
    assign rd_end    = rdata[PAGE_W-1:0];
    assign i_plus1   = CW'(r_i) + CW'(1);
    assign i_plus2   = CW'(r_i) + CW'(2);

    always_comb begin
        case (i_cmd.rd_src)
            RS_PTR:   raddr = r_ptr[IW-1:0];
            RS_PTRM1: raddr = IW'(r_ptr - CW'(1));
            default:  raddr = r_idx;
        endcase
    end

    always_comb begin
        waddr   = r_i;
        w_first = r_lf;
        w_end   = max_le_ep;
        case (i_cmd.wr_sel)
            W_HEAD: begin
                waddr   = '0;
                w_first = r_sp;
            end
            W_LMAX: begin
                waddr = r_i;
            end
            W_LRE: begin
                w_end = r_re;
            end
            W_RSP: begin
                waddr   = i_plus1[IW-1:0];
                w_first = r_sp;
                w_end   = r_re;
            end
            W_SHUP: begin
                waddr   = r_ptr[IW-1:0];
                w_first = rd_first;
                w_end   = rd_end;
            end
            W_SHDN: begin
                waddr   = IW'(r_ptr - CW'(1));
                w_first = rd_first;
                w_end   = rd_end;
            end
            W_INS: begin
                waddr   = r_pos[IW-1:0];
                w_first = r_sp;
                w_end   = r_ep;
            end
            default: begin
                waddr = r_i;
            end
        endcase
        wdata = {w_first, w_end};
    end

    rmt_ram #(
        .WIDTH(2 * PAGE_W),
        .DEPTH(MAX_SPANS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_en),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (i_cmd.rd_en),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        case (i_cmd.emit_sel)
            ES_LEFT:  begin e_first = r_lf; e_end = r_le;      end
            ES_RIGHT: begin e_first = r_rf; e_end = r_re;      end
            ES_LMAX:  begin e_first = r_lf; e_end = max_le_ep; end
            ES_HEAD:  begin e_first = r_sp; e_end = max_le_ep; end
            ES_SPRE:  begin e_first = r_sp; e_end = r_re;      end
            ES_LRE:   begin e_first = r_lf; e_end = r_re;      end
            default:  begin e_first = r_sp; e_end = r_ep;      end
        endcase
    end

    always_comb begin
        o_stat.reject       = (r_sp == '0);
        o_stat.empty        = (r_total == '0);
        o_stat.full         = (r_total == CW'(MAX_SPANS));
        o_stat.head_le      = (r_sp <= rd_first);
        o_stat.head_ep_ge   = (r_ep >= rd_first);
        o_stat.rd_lt_sp     = (rd_first < r_sp);
        o_stat.at_last      = (CW'(r_idx) + CW'(1) >= r_total);
        o_stat.idx_zero     = (r_idx == '0);
        o_stat.left_hit     = (r_le >= r_sp);
        o_stat.right_hit    = (r_rf <= r_ep);
        o_stat.ptr_gt_pos   = (r_ptr > r_pos);
        o_stat.ptr_lt_total = (r_ptr < r_total);
        o_stat.out_free     = !r_ov || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.tot_inc) begin
                r_total <= r_total + CW'(1);
            end else if (i_cmd.tot_dec) begin
                r_total <= r_total - CW'(1);
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sp  <= i_fault_address[ADDR_W-1:PAGE_BITS];
            r_ep  <= sum[ADDR_W-1:PAGE_BITS];
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.cap_left) begin
            r_lf <= rd_first;
            r_le <= rd_end;
            r_i  <= r_idx;
        end
        if (i_cmd.cap_right) begin
            r_rf <= rd_first;
            r_re <= rd_end;
        end
        if (i_cmd.pos_set) begin
            r_pos <= i_cmd.pos_i1 ? i_plus1 : '0;
        end
        case (i_cmd.ptr_op)
            P_TOTAL: r_ptr <= r_total;
            P_I2:    r_ptr <= i_plus2;
            P_INC:   r_ptr <= r_ptr + CW'(1);
            P_DEC:   r_ptr <= r_ptr - CW'(1);
            default: r_ptr <= r_ptr;
        endcase
        if (i_cmd.emit) begin
            r_ocmd   <= i_cmd.emit_cmd;
            r_ostart <= e_first;
            r_oend   <= e_end;
            r_olast  <= i_cmd.emit_last;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_command     = r_ocmd;
    assign o_range_start = {r_ostart, {PAGE_BITS{1'b0}}};
    assign o_range_end   = {r_oend, {PAGE_BITS{1'b0}}};
    assign o_last_of_run = r_olast;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(MAX_SPANS))
        else $error("span count above capacity");
    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ocmd == CMD_REJECT) |-> r_olast)
        else $error("reject not last of run");
    a_full_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ocmd == CMD_FULL) |-> r_olast)
        else $error("full status not last of run");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_ov) |-> i_out_ready)
        else $error("result overwritten before transfer");
endmodule

// File: rtl/mapped_range_merge_table.sv
// Page-range merge table. Each transfer on the input channel carries a faulting
// address and access size; they are rounded out to 4 KiB pages and merged into a
// sorted table of up to MAX_SPANS disjoint ranges held in a RAM with one write
// port and one registered read port. One item yields one to three commands on
// the output channel, the last flagged by o_last_of_run. An item scans the table
// entries in order to find its place, then moves table entries when an insert or
// a double merge shifts the table, then issues its commands, which the output
// channel can stall. Scan and shift together cover the table about once. Table
// contents need no clearing after reset; only the entry count is reset. One item
// is in work at a time.
module mapped_range_merge_table #(
    parameter int MAX_SPANS = rmt_pkg::MAX_SPANS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [rmt_pkg::ADDR_W-1:0]  i_fault_address,
    input  logic [rmt_pkg::SIZE_W-1:0]  i_access_size,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_command,
    output logic [rmt_pkg::ADDR_W-1:0]  o_range_start,
    output logic [rmt_pkg::ADDR_W-1:0]  o_range_end,
    output logic                        o_last_of_run
);
    import rmt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rmt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    rmt_dp #(
        .MAX_SPANS(MAX_SPANS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_fault_address(i_fault_address),
        .i_access_size  (i_access_size),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_command      (o_command),
        .o_range_start  (o_range_start),
        .o_range_end    (o_range_end),
        .o_last_of_run  (o_last_of_run)
    );
endmodule

// File: tb/tb.sv
module tb;
    import rmt_pkg::*;

    localparam int TABLE_DEPTH = MAX_SPANS_DEF;
    localparam logic [63:0] REGION_BASE = 64'h0000_0000_1000_0000;

    typedef struct {
        t_cmd_code         cmd;
        logic [ADDR_W-1:0] range_start;
        logic [ADDR_W-1:0] range_end;
        logic              last_run;
    } t_range_cmd;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [ADDR_W-1:0]  i_fault_address;
    logic [SIZE_W-1:0]  i_access_size;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_command;
    logic [ADDR_W-1:0]  o_range_start;
    logic [ADDR_W-1:0]  o_range_end;
    logic               o_last_of_run;

    mapped_range_merge_table DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_fault_address (i_fault_address),
        .i_access_size   (i_access_size),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_command       (o_command),
        .o_range_start   (o_range_start),
        .o_range_end     (o_range_end),
        .o_last_of_run   (o_last_of_run)
    );

    // shadow copy of the span table
    logic [PAGE_W-1:0] span_first[TABLE_DEPTH];
    logic [PAGE_W-1:0] span_end[TABLE_DEPTH];
    int                shadow_total;

    t_range_cmd expected_cmds[$];
    int         mismatch_count;
    int         hold_cycles;
    bit         quiet_mode;
    bit         reset_done;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void push_cmd(t_cmd_code cmd, logic [PAGE_W-1:0] sp,
                                     logic [PAGE_W-1:0] ep);
        t_range_cmd c;
        c.cmd         = cmd;
        c.range_start = {sp, 12'h000};
        c.range_end   = {ep, 12'h000};
        c.last_run    = 1'b0;
        expected_cmds.push_back(c);
    endfunction

    function automatic void insert_span(int pos, logic [PAGE_W-1:0] sp,
                                        logic [PAGE_W-1:0] ep);
        if (shadow_total >= TABLE_DEPTH) begin
            push_cmd(CMD_FULL, sp, ep);
            return;
        end
        for (int j = shadow_total; j > pos; j--) begin
            span_first[j] = span_first[j-1];
            span_end[j]   = span_end[j-1];
        end
        span_first[pos] = sp;
        span_end[pos]   = ep;
        shadow_total++;
        push_cmd(CMD_MAP, sp, ep);
    endfunction

    function automatic void predict_commands(logic [63:0] addr, logic [15:0] size);
        logic [63:0]       end_byte;
        logic [PAGE_W-1:0] sp;
        logic [PAGE_W-1:0] ep;
        int                i;
        bit                left_hit;
        bit                right_hit;
        end_byte = addr + {48'd0, size} + PAGE_MASK;
        sp = addr[63:12];
        ep = end_byte[63:12];
        if (sp == '0) begin
            push_cmd(CMD_REJECT, sp, ep);
        end else if (shadow_total == 0) begin
            insert_span(0, sp, ep);
        end else if (sp <= span_first[0]) begin
            if (ep >= span_first[0]) begin
                push_cmd(CMD_UNMAP, span_first[0], span_end[0]);
                span_first[0] = sp;
                if (ep > span_end[0]) span_end[0] = ep;
                push_cmd(CMD_MAP, span_first[0], span_end[0]);
            end else begin
                insert_span(0, sp, ep);
            end
        end else begin
            i = 0;
            while (i + 1 < shadow_total && span_first[i+1] < sp) i++;
            if (i + 1 >= shadow_total) begin
                if (span_end[i] >= sp) begin
                    push_cmd(CMD_UNMAP, span_first[i], span_end[i]);
                    if (ep > span_end[i]) span_end[i] = ep;
                    push_cmd(CMD_MAP, span_first[i], span_end[i]);
                end else begin
                    insert_span(i + 1, sp, ep);
                end
            end else begin
                left_hit  = span_end[i] >= sp;
                right_hit = span_first[i+1] <= ep;
                if (left_hit && right_hit) begin
                    push_cmd(CMD_UNMAP, span_first[i], span_end[i]);
                    push_cmd(CMD_UNMAP, span_first[i+1], span_end[i+1]);
                    span_end[i] = span_end[i+1];
                    for (int j = i + 1; j < shadow_total - 1; j++) begin
                        span_first[j] = span_first[j+1];
                        span_end[j]   = span_end[j+1];
                    end
                    shadow_total--;
                    push_cmd(CMD_MAP, span_first[i], span_end[i]);
                end else if (left_hit) begin
                    push_cmd(CMD_UNMAP, span_first[i], span_end[i]);
                    if (ep > span_end[i]) span_end[i] = ep;
                    push_cmd(CMD_MAP, span_first[i], span_end[i]);
                end else if (right_hit) begin
                    push_cmd(CMD_UNMAP, span_first[i+1], span_end[i+1]);
                    span_first[i+1] = sp;
                    push_cmd(CMD_MAP, sp, span_end[i+1]);
                end else begin
                    insert_span(i + 1, sp, ep);
                end
            end
        end
        expected_cmds[expected_cmds.size()-1].last_run = 1'b1;
    endfunction

    task automatic check_command();
        t_range_cmd e;
        if (expected_cmds.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected command %0d start %h end %h last %b",
                         o_command, o_range_start, o_range_end, o_last_of_run);
            return;
        end
        e = expected_cmds.pop_front();
        if (o_command !== e.cmd || o_range_start !== e.range_start ||
            o_range_end !== e.range_end || o_last_of_run !== e.last_run) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch: exp cmd %0d %h..%h last %b, got cmd %0d %h..%h last %b",
                         e.cmd, e.range_start, e.range_end, e.last_run,
                         o_command, o_range_start, o_range_end, o_last_of_run);
        end
    endtask

    // receiver: random stall bursts plus an optional long hold-off
    initial begin : receiver
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        wait (reset_done);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) check_command();
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 5);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // call at a rising edge; returns at the edge where the transfer happens
    task automatic send_fault(logic [63:0] addr, logic [15:0] size);
        if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_fault_address <= addr;
        i_access_size   <= size;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_commands(addr, size);
    endtask

    task automatic test_low_address();
        send_fault(64'h0, 16'h0);
        send_fault(64'hFFF, 16'hFFFF);
        send_fault(64'h800, 16'h1);
    endtask

    task automatic test_merge_cases();
        send_fault(64'h0000_0000_0010_0000, 16'h0800);  // first span
        send_fault(64'h0000_0000_000F_F000, 16'h1000);  // head merge
        send_fault(64'h0000_0000_0008_0000, 16'h0010);  // head insert
        send_fault(64'h0000_0000_0010_1000, 16'h2000);  // tail merge
        send_fault(64'h0000_0000_0020_0000, 16'hFFFF);  // tail insert
        send_fault(64'h0000_0000_0018_0000, 16'h0001);  // middle insert
        send_fault(64'h0000_0000_0018_1000, 16'h0100);  // left merge
        send_fault(64'h0000_0000_001F_F000, 16'h0004);  // right merge
        send_fault(64'h0000_0000_0018_2000, 16'hF000);  // left only, no reach
        send_fault(64'h0000_0000_0019_0000, 16'h0000);  // left merge, already covered
        send_fault(64'h0000_0000_0018_F000, 16'h1000);  // left merge, already covered
        send_fault(64'h0000_0000_0000_1000, 16'h0000);  // lowest accepted page
    endtask

    task automatic test_end_wrap();
        send_fault(64'hFFFF_FFFF_FFFF_F000, 16'h1000);
        send_fault(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        send_fault(64'h8000_0000_0000_0000, 16'h1234);
    endtask

    task automatic test_fill_table();
        int order[$];
        int a, b, t;
        for (int k = 0; k < 72; k++) order.push_back(k);
        for (int k = 0; k < 200; k++) begin
            a = $urandom_range(0, 71);
            b = $urandom_range(0, 71);
            t = order[a]; order[a] = order[b]; order[b] = t;
        end
        hold_cycles = 600;  // long receiver hold-off while items keep coming
        foreach (order[k])
            send_fault(REGION_BASE + 64'(order[k]) * 64'h4000, 16'(order[k] * 37));
    endtask

    task automatic test_random(int count);
        logic [63:0] addr;
        for (int k = 0; k < count; k++) begin
            if (k == count - 60) quiet_mode = 1'b1;
            case ($urandom_range(0, 9))
                0:       addr = 64'($urandom_range(0, 32'h2FFF));
                1, 2:    addr = {$urandom, $urandom};
                default: addr = REGION_BASE + 64'($urandom_range(0, 32'h0012_0000));
            endcase
            send_fault(addr, 16'($urandom));
        end
    endtask

    initial begin : main
        int waited;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_fault_address = '0;
        i_access_size   = '0;
        shadow_total    = 0;
        mismatch_count  = 0;
        hold_cycles     = 0;
        quiet_mode      = 1'b0;
        reset_done      = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        reset_done = 1'b1;
        @(posedge i_clk);

        test_low_address();
        test_merge_cases();
        test_end_wrap();
        test_fill_table();
        test_random(260);
        i_in_valid <= 1'b0;

        waited = 0;
        while (expected_cmds.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (300) @(posedge i_clk);
        if (mismatch_count == 0 && expected_cmds.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/rmt_pkg.sv
rtl/rmt_ram.sv
rtl/rmt_ctrl.sv
rtl/rmt_dp.sv
rtl/mapped_range_merge_table.sv
tb/tb.sv
